/* hw/rtl/bb3_pkg.sv */
// Shared types, constants and the reciprocal table for the 3x3 box blur.
`timescale 1ns / 1ps
package bb3_pkg;

    // Configuration register indexes
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    localparam logic [10:0] WIDTH_RESET  = 11'd1024;
    localparam logic [12:0] HEIGHT_RESET = 13'd4096;

    // Fixed-point division: q = (x * recip) >> RECIP_SHIFT
    localparam int RECIP_SHIFT = 16;

    typedef struct packed {
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } t_pix_in;

    typedef struct packed {
        logic [7:0]  red_out;
        logic [7:0]  green_out;
        logic [7:0]  blue_out;
        logic [11:0] out_row;
        logic [9:0]  out_col;
        logic        last_of_run;
        logic        frame_done;
    } t_pix_out;

    // One pending result: rounded sums (sum + n/2) and the divisor
    typedef struct packed {
        logic [11:0] x_red;
        logic [11:0] x_green;
        logic [11:0] x_blue;
        logic [3:0]  n;
        logic [11:0] row;
        logic [9:0]  col;
        logic        last;
        logic        done;
    } t_job;

    // Reciprocal of the pixel count, scaled by 2^16 and rounded up;
    // exact for every sum below 2^15
    function automatic logic [16:0] recip(input logic [3:0] n);
        logic [16:0] m;
        case (n)
            4'd1:    m = 17'd65536;
            4'd2:    m = 17'd32768;
            4'd3:    m = 17'd21846;
            4'd4:    m = 17'd16384;
            4'd6:    m = 17'd10923;
            4'd9:    m = 17'd7282;
            default: m = 17'd65536;
        endcase
        return m;
    endfunction

endpackage

/* hw/rtl/bb3_fifo.sv */
// Small register-based queue with push/full and pop/empty sides.
`timescale 1ns / 1ps
module bb3_fifo #(
    parameter int W = 8,
    parameter int L = 2
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_empty
);
    localparam int DEPTH = 2 ** L;

    logic [W-1:0] r_mem [DEPTH];
    logic [L-1:0] r_wr;
    logic [L-1:0] r_rd;
    logic [L:0]   r_cnt;
    logic         do_push;
    logic         do_pop;

    assign o_full  = (r_cnt == (L+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wr <= r_wr + 1'b1;
            if (do_pop)  r_rd <= r_rd + 1'b1;
            if (do_push && !do_pop) r_cnt <= r_cnt + 1'b1;
            else if (do_pop && !do_push) r_cnt <= r_cnt - 1'b1;
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr] <= i_data;
    end

endmodule

/* hw/rtl/bb3_front.sv */
// Front end: takes pixels, keeps line stores and window, issues one job per result.
`timescale 1ns / 1ps
module bb3_front #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  bb3_pkg::t_pix_in i_pix,
    output logic             o_full,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [12:0]      i_cfg_data,
    output logic             o_job_push,
    output bb3_pkg::t_job    o_job,
    input  logic             i_job_full
);
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_LOAD = 3'b010,
        S_EMIT = 3'b100
    } t_state;

    t_state  r_state;
    t_state  n_state;

    logic [10:0]  r_width;
    logic [12:0]  r_height;
    logic [WW-1:0] w_eff;
    logic [HW-1:0] h_eff;

    logic [RW-1:0] r_row;
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row_q;
    logic [CW-1:0] r_col_q;
    logic          r_row_ge1;
    logic          r_row_ge2;
    logic          r_col_ge1;
    logic          r_col_ge2;
    logic [3:0]    r_mask;

    logic [23:0] r_up_mem [MAX_WIDTH];
    logic [23:0] r_lo_mem [MAX_WIDTH];
    logic [23:0] r_up_rd;
    logic [23:0] r_lo_rd;
    logic [23:0] r_pix;
    logic [23:0] r_win [3][3];

    logic        accept;
    logic        last_col;
    logic        last_row;
    logic [3:0]  mask_new;
    logic [3:0]  sel;
    logic        prev_row;
    logic        prev_col;
    logic [2:0]  row_m;
    logic [2:0]  col_m;
    logic [1:0]  cnt_r;
    logic [1:0]  cnt_c;
    logic [3:0]  n_pix;
    logic [11:0] sum_r;
    logic [11:0] sum_g;
    logic [11:0] sum_b;
    logic        job_go;

    assign accept = i_push && (r_state == S_IDLE);
    assign o_full = (r_state != S_IDLE);

    // Frame size clamped to 1..MAX
    always_comb begin
        if (r_width == '0) w_eff = WW'(1);
        else if (int'(r_width) > MAX_WIDTH) w_eff = WW'(MAX_WIDTH);
        else w_eff = WW'(r_width);
        if (r_height == '0) h_eff = HW'(1);
        else if (int'(r_height) > MAX_HEIGHT) h_eff = HW'(MAX_HEIGHT);
        else h_eff = HW'(r_height);
    end

    assign last_col = ((WW'(r_col) + WW'(1)) == w_eff);
    assign last_row = ((HW'(r_row) + HW'(1)) == h_eff);

    // Which pixels this input completes: up-left, up, left, here
    assign mask_new[0] = (r_row != '0) && (r_col != '0);
    assign mask_new[1] = (r_row != '0) && last_col;
    assign mask_new[2] = last_row && (r_col != '0);
    assign mask_new[3] = last_row && last_col;

    // Control state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_push) n_state = S_LOAD;
            S_LOAD: n_state = (mask_new != '0) ? S_EMIT : S_IDLE;
            S_EMIT: if (job_go && ((r_mask & ~sel) == '0)) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_width  <= bb3_pkg::WIDTH_RESET;
            r_height <= bb3_pkg::HEIGHT_RESET;
            r_row    <= '0;
            r_col    <= '0;
            r_mask   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_LOAD) begin
                r_mask <= mask_new;
                if (last_col) begin
                    r_col <= '0;
                    r_row <= last_row ? '0 : r_row + 1'b1;
                end else begin
                    r_col <= r_col + 1'b1;
                end
            end else if (job_go) begin
                r_mask <= r_mask & ~sel;
            end
            // register write restarts the frame
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    bb3_pkg::REG_WIDTH:  r_width  <= i_cfg_data[10:0];
                    bb3_pkg::REG_HEIGHT: r_height <= i_cfg_data;
                    default: ;
                endcase
                r_row <= '0;
                r_col <= '0;
            end
        end
    end

    // Line stores: read on accept, written back in the load cycle
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_up_rd <= r_up_mem[r_col];
            r_lo_rd <= r_lo_mem[r_col];
        end
        if (r_state == S_LOAD) begin
            r_up_mem[r_col] <= r_lo_rd;
            r_lo_mem[r_col] <= r_pix;
        end
    end

    // Pixel latch, window shift and position snapshot
    always_ff @(posedge i_clk) begin
        if (accept) r_pix <= i_pix;
        if (r_state == S_LOAD) begin
            for (int i = 0; i < 3; i++) begin
                r_win[i][0] <= r_win[i][1];
                r_win[i][1] <= r_win[i][2];
            end
            r_win[0][2] <= r_up_rd;
            r_win[1][2] <= r_lo_rd;
            r_win[2][2] <= r_pix;
            r_row_q   <= r_row;
            r_col_q   <= r_col;
            r_row_ge1 <= (r_row != '0);
            r_row_ge2 <= (r_row > RW'(1));
            r_col_ge1 <= (r_col != '0);
            r_col_ge2 <= (r_col > CW'(1));
        end
    end

    // Lowest pending result first
    always_comb begin
        sel = '0;
        if (r_mask[0]) sel = 4'b0001;
        else if (r_mask[1]) sel = 4'b0010;
        else if (r_mask[2]) sel = 4'b0100;
        else if (r_mask[3]) sel = 4'b1000;
    end

    assign prev_row = sel[0] | sel[1];
    assign prev_col = sel[0] | sel[2];
    assign row_m = prev_row ? {1'b1, 1'b1, r_row_ge2} : {1'b1, r_row_ge1, 1'b0};
    assign col_m = prev_col ? {1'b1, 1'b1, r_col_ge2} : {1'b1, r_col_ge1, 1'b0};
    assign cnt_r = 2'(row_m[0]) + 2'(row_m[1]) + 2'(row_m[2]);
    assign cnt_c = 2'(col_m[0]) + 2'(col_m[1]) + 2'(col_m[2]);
    assign n_pix = 4'(cnt_r * cnt_c);

    // Masked channel sums over the in-bounds neighbourhood
    always_comb begin
        sum_r = '0;
        sum_g = '0;
        sum_b = '0;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                if (row_m[i] && col_m[j]) begin
                    sum_r = sum_r + 12'(r_win[i][j][23:16]);
                    sum_g = sum_g + 12'(r_win[i][j][15:8]);
                    sum_b = sum_b + 12'(r_win[i][j][7:0]);
                end
            end
        end
    end

    assign job_go     = (r_state == S_EMIT) && !i_job_full;
    assign o_job_push = (r_state == S_EMIT);

    always_comb begin
        o_job.x_red   = sum_r + 12'(n_pix >> 1);
        o_job.x_green = sum_g + 12'(n_pix >> 1);
        o_job.x_blue  = sum_b + 12'(n_pix >> 1);
        o_job.n       = n_pix;
        o_job.row     = prev_row ? 12'(r_row_q - 1'b1) : 12'(r_row_q);
        o_job.col     = prev_col ? 10'(r_col_q - 1'b1) : 10'(r_col_q);
        o_job.last    = ((r_mask & ~sel) == '0);
        o_job.done    = sel[3];
    end

endmodule

/* hw/rtl/bb3_back.sv */
// Back end: divides the rounded sums by the pixel count via reciprocal multiply.
`timescale 1ns / 1ps
module bb3_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bb3_pkg::t_job     i_job,
    input  logic              i_job_empty,
    output logic              o_job_pop,
    output logic              o_out_push,
    output bb3_pkg::t_pix_out o_out,
    input  logic              i_out_full
);
    logic          r_v;
    bb3_pkg::t_job r_job;
    logic [16:0]   r_m;
    logic [28:0]   p_r;
    logic [28:0]   p_g;
    logic [28:0]   p_b;

    assign o_out_push = r_v;
    assign o_job_pop  = !i_job_empty && (!r_v || !i_out_full);

    // Operand stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (!r_v || !i_out_full) begin
            r_v <= !i_job_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_job_pop) begin
            r_job <= i_job;
            r_m   <= bb3_pkg::recip(i_job.n);
        end
    end

    // Multiply; the quotient is a bit-select, registered by the output queue
    assign p_r = 29'(r_job.x_red) * 29'(r_m);
    assign p_g = 29'(r_job.x_green) * 29'(r_m);
    assign p_b = 29'(r_job.x_blue) * 29'(r_m);

    always_comb begin
        o_out.red_out     = p_r[bb3_pkg::RECIP_SHIFT +: 8];
        o_out.green_out   = p_g[bb3_pkg::RECIP_SHIFT +: 8];
        o_out.blue_out    = p_b[bb3_pkg::RECIP_SHIFT +: 8];
        o_out.out_row     = r_job.row;
        o_out.out_col     = r_job.col;
        o_out.last_of_run = r_job.last;
        o_out.frame_done  = r_job.done;
    end

endmodule

/* hw/rtl/box_blur_3x3_edge_aware.sv */
// Top level of the streaming 3x3 box blur with in-bounds averaging.
//
//  channel   | signals                         | beat taken when
//  ----------+---------------------------------+-------------------
//  pixel in  | push, full, i_pix               | push && !full
//  result    | empty, pop, o_pix               | pop && !empty
//  config    | i_cfg_we, i_cfg_idx, i_cfg_data | i_cfg_we
//
// A pixel passes the front end as a line store read, then a window update,
// then issues one job per result it completes (0 to 4) through the single
// job issue port. Jobs pass the job queue and back-end operand register.
// Reset is synchronous, active low; line stores keep no reset.
// Job and result queues hold 4 beats each, so either side can stall alone.
`timescale 1ns / 1ps
module box_blur_3x3_edge_aware #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  bb3_pkg::t_pix_in  i_pix,
    output logic              empty,
    input  logic              pop,
    output bb3_pkg::t_pix_out o_pix,
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [12:0]       i_cfg_data
);
    logic              job_push;
    logic              job_full;
    logic              job_pop;
    logic              job_empty;
    bb3_pkg::t_job     job_in;
    logic [$bits(bb3_pkg::t_job)-1:0] job_q;
    logic              out_push;
    logic              out_full;
    bb3_pkg::t_pix_out out_in;
    logic [$bits(bb3_pkg::t_pix_out)-1:0] out_q;

    bb3_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_pix      (i_pix),
        .o_full     (full),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_job_push (job_push),
        .o_job      (job_in),
        .i_job_full (job_full)
    );

    bb3_fifo #(
        .W ($bits(bb3_pkg::t_job)),
        .L (2)
    ) u_job_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_data  (job_in),
        .o_full  (job_full),
        .i_pop   (job_pop),
        .o_data  (job_q),
        .o_empty (job_empty)
    );

    bb3_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (bb3_pkg::t_job'(job_q)),
        .i_job_empty (job_empty),
        .o_job_pop   (job_pop),
        .o_out_push  (out_push),
        .o_out       (out_in),
        .i_out_full  (out_full)
    );

    bb3_fifo #(
        .W ($bits(bb3_pkg::t_pix_out)),
        .L (2)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_data  (out_in),
        .o_full  (out_full),
        .i_pop   (pop),
        .o_data  (out_q),
        .o_empty (empty)
    );

    assign o_pix = bb3_pkg::t_pix_out'(out_q);

    // Checks
    a_front_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !full) |=> full)
        else $error("front end took a second beat while busy");

    a_back_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_push && out_full) |=> out_push && $stable(out_in))
        else $error("stalled result changed in back end");

    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_pix.frame_done) |-> o_pix.last_of_run)
        else $error("frame end result not marked last of run");

    a_pop_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (job_pop && !job_empty) |-> (!$isunknown(job_q)))
        else $error("job queue delivered an undefined beat");

endmodule
